FILE: rtl/interval_paint_map_core_assert.svh
// ---------------------------------------------------------------------------
// Interval paint map assertion macros
// Shorthand for clocked assertions, sampled on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef INTERVAL_PAINT_MAP_CORE_ASSERT_SVH
`define INTERVAL_PAINT_MAP_CORE_ASSERT_SVH

// same-cycle implication
`define IPM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IPM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ipm_pkg.sv
// ---------------------------------------------------------------------------
// ipm_pkg
// Types, codes and widths shared by the interval paint map files.
// ---------------------------------------------------------------------------
`default_nettype none

package ipm_pkg;

	localparam int KEY_W           = 16;
	localparam int COLOR_W         = 32;
	localparam int TABLE_DEPTH_DEF = 32;
	localparam int APB_DATA_W      = 32;
	localparam int APB_ADDR_W      = 3;

	// register index, taken from paddr[2]
	localparam logic REG_KEY_LIMIT  = 1'b0;
	localparam logic REG_INIT_COLOR = 1'b1;

	typedef enum logic [0:0] {
		CMD_PAINT = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [KEY_W-1:0]   start_key;
		logic [KEY_W-1:0]   end_key;
		logic [COLOR_W-1:0] color;
	} in_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]   seg_left;
		logic [KEY_W-1:0]   seg_right;
		logic [COLOR_W-1:0] seg_color;
		status_t            status;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [COLOR_W-1:0] color;
	} entry_t;

	typedef struct packed {
		logic lt_a;
		logic le_a;
		logic le_b;
		logic eq_b;
	} cmp_res_t;

	typedef struct packed {
		logic rd_en;
		logic rd_bank;
		logic wr_en;
		logic wr_bank;
	} mem_ctl_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_COPY_LO,
		S_INS_A,
		S_EMIT_RD,
		S_EMIT_WAIT,
		S_EMIT_FIN,
		S_INS_B,
		S_COPY_HI,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/ipm_mem.sv
// ---------------------------------------------------------------------------
// ipm_mem
// One breakpoint bank: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module ipm_mem
	import ipm_pkg::*;
#(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire entry_t           wr_data,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output entry_t                rd_data
);

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ipm_cmp.sv
// ---------------------------------------------------------------------------
// ipm_cmp
// Shared key compare unit: one stored key against the item's range bounds.
// ---------------------------------------------------------------------------
`default_nettype none

module ipm_cmp
	import ipm_pkg::*;
(
	input  wire logic [KEY_W-1:0] key,
	input  wire logic [KEY_W-1:0] lo_key,
	input  wire logic [KEY_W-1:0] hi_key,
	output cmp_res_t              res
);

	always_comb begin
		res.lt_a = key < lo_key;
		res.le_a = key <= lo_key;
		res.le_b = key <= hi_key;
		res.eq_b = key == hi_key;
	end

endmodule

`default_nettype wire

FILE: rtl/ipm_ctrl.sv
// ---------------------------------------------------------------------------
// ipm_ctrl
// Sequencer: scans the active bank, emits covered segments and rebuilds the
// table into the other bank.
// ---------------------------------------------------------------------------
`default_nettype none

module ipm_ctrl
	import ipm_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int IDX_W       = $clog2(TABLE_DEPTH),
	parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [KEY_W-1:0]   key_limit,
	input  wire logic [COLOR_W-1:0] init_color,
	input  wire logic               cfg_write,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire in_item_t           in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output out_item_t               out_item,
	output mem_ctl_t                mem_ctl,
	output logic [IDX_W-1:0]        rd_addr,
	output logic [IDX_W-1:0]        wr_addr,
	output entry_t                  wr_data,
	input  wire entry_t             rd_data
);

	localparam int SUM_W = $clog2(2 * TABLE_DEPTH + 2) + 1;

	state_t             state_q, state_d;
	logic               bank_q;
	logic [CNT_W-1:0]   n_q;
	in_item_t           item_q;
	logic [CNT_W-1:0]   rp_q, end_q, wp_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               got_i_q, got_t_q, got_c_q;
	logic [IDX_W-1:0]   i_q, t_q;
	logic               eq_q, add_q;
	logic [COLOR_W-1:0] color_i_q, color_t_q, qcolor_q;
	logic [KEY_W-1:0]   pos_q;
	out_item_t          resp_q;
	logic               out_valid_q;
	out_item_t          out_q;

	cmp_res_t           cmp;
	logic               accept, item_ok, streaming, issue, stream_done, out_free;
	logic               full, last_hit, add_d;
	logic [CNT_W-1:0]   j_idx, t_cnt, rp_inc;
	logic [SUM_W-1:0]   new_size;
	logic               load;
	out_item_t          out_d;

	ipm_cmp u_cmp (
		.key    (rd_data.key),
		.lo_key (item_q.start_key),
		.hi_key (item_q.end_key),
		.res    (cmp)
	);

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign j_idx    = CNT_W'(i_q) + CNT_W'(eq_q);
	assign t_cnt    = CNT_W'(t_q);
	assign rp_inc   = rp_q + 1'b1;
	assign last_hit = (rp_inc == t_cnt) && cmp.eq_b;
	// a paint from key zero leaves no empty segment in front
	assign add_d    = eq_q || (item_q.start_key != '0);
	assign new_size = SUM_W'(i_q) + SUM_W'(add_d) + SUM_W'(1) + SUM_W'(n_q)
		- SUM_W'(t_q);
	assign full     = new_size > SUM_W'(TABLE_DEPTH);

	always_comb begin
		if (in_item.cmd == CMD_QUERY) begin
			item_ok = in_item.start_key < key_limit;
		end else begin
			item_ok = (in_item.start_key < in_item.end_key) && (in_item.end_key < key_limit);
		end
	end

	assign streaming   = (state_q == S_SCAN) || (state_q == S_COPY_LO) || (state_q == S_COPY_HI);
	assign stream_done = (rp_q == end_q) && !vld_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					state_d = item_ok ? S_SCAN : S_RESP;
				end
			end
			S_SCAN: begin
				if (stream_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (item_q.cmd == CMD_QUERY || full) begin
					state_d = S_RESP;
				end else if (i_q == '0) begin
					state_d = S_INS_A;
				end else begin
					state_d = S_COPY_LO;
				end
			end
			S_COPY_LO: begin
				if (stream_done) begin
					state_d = S_INS_A;
				end
			end
			S_INS_A: state_d = (j_idx < t_cnt) ? S_EMIT_RD : S_EMIT_FIN;
			S_EMIT_RD: state_d = S_EMIT_WAIT;
			S_EMIT_WAIT: begin
				if (out_free) begin
					if (last_hit) begin
						state_d = S_INS_B;
					end else if (rp_inc < t_cnt) begin
						state_d = S_EMIT_RD;
					end else begin
						state_d = S_EMIT_FIN;
					end
				end
			end
			S_EMIT_FIN: begin
				if (out_free) begin
					state_d = S_INS_B;
				end
			end
			S_INS_B: state_d = S_COPY_HI;
			S_COPY_HI: begin
				if (stream_done) begin
					state_d = S_IDLE;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
		if (cfg_write) begin
			state_d = S_INIT;
		end
	end

	// outputs
	always_comb begin
		issue            = (streaming && rp_q != end_q) || state_q == S_EMIT_RD;
		in_stall         = state_q != S_IDLE;
		mem_ctl.rd_en    = issue;
		mem_ctl.rd_bank  = bank_q;
		mem_ctl.wr_en    = 1'b0;
		mem_ctl.wr_bank  = !bank_q;
		rd_addr          = rp_q[IDX_W-1:0];
		wr_addr          = wp_q[IDX_W-1:0];
		wr_data          = rd_data;
		load             = 1'b0;
		out_d            = resp_q;
		unique case (state_q)
			S_INIT: begin
				mem_ctl.wr_en   = 1'b1;
				mem_ctl.wr_bank = bank_q;
				wr_addr         = '0;
				wr_data.key     = key_limit;
				wr_data.color   = init_color;
			end
			S_COPY_LO, S_COPY_HI: mem_ctl.wr_en = vld_s1;
			S_INS_A: begin
				mem_ctl.wr_en = add_q;
				wr_data.key   = item_q.start_key;
				wr_data.color = color_i_q;
			end
			S_INS_B: begin
				mem_ctl.wr_en = 1'b1;
				wr_data.key   = item_q.end_key;
				wr_data.color = item_q.color;
			end
			S_EMIT_WAIT: begin
				load            = out_free;
				out_d.seg_left  = pos_q;
				out_d.seg_right = rd_data.key;
				out_d.seg_color = rd_data.color;
				out_d.status    = ST_OK;
				out_d.last      = last_hit;
			end
			S_EMIT_FIN: begin
				load            = out_free;
				out_d.seg_left  = pos_q;
				out_d.seg_right = item_q.end_key;
				out_d.seg_color = color_t_q;
				out_d.status    = ST_OK;
				out_d.last      = 1'b1;
			end
			S_RESP: load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			bank_q      <= 1'b0;
			n_q         <= CNT_W'(1);
			rp_q        <= '0;
			end_q       <= '0;
			wp_q        <= '0;
			vld_s1      <= 1'b0;
			got_i_q     <= 1'b0;
			got_t_q     <= 1'b0;
			got_c_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue && streaming && !cfg_write;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				rp_q  <= '0;
				end_q <= '0;
			end else begin
				unique case (state_q)
					S_INIT: n_q <= CNT_W'(1);
					S_IDLE: begin
						rp_q    <= '0;
						end_q   <= n_q;
						got_i_q <= 1'b0;
						got_t_q <= 1'b0;
						got_c_q <= 1'b0;
					end
					S_SCAN: begin
						if (issue) begin
							rp_q <= rp_inc;
						end
						if (vld_s1) begin
							if (!got_i_q && !cmp.lt_a) begin
								got_i_q <= 1'b1;
							end
							if (!got_t_q && !cmp.le_b) begin
								got_t_q <= 1'b1;
							end
							if (!got_c_q && !cmp.le_a) begin
								got_c_q <= 1'b1;
							end
						end
					end
					S_DECIDE: begin
						rp_q  <= '0;
						end_q <= CNT_W'(i_q);
						wp_q  <= '0;
					end
					S_COPY_LO, S_COPY_HI: begin
						if (issue) begin
							rp_q <= rp_inc;
						end
						if (vld_s1) begin
							wp_q <= wp_q + 1'b1;
						end
						if (state_q == S_COPY_HI && stream_done) begin
							bank_q <= !bank_q;
							n_q    <= wp_q;
						end
					end
					S_INS_A: begin
						if (add_q) begin
							wp_q <= wp_q + 1'b1;
						end
						rp_q <= j_idx;
					end
					S_EMIT_WAIT: begin
						if (out_free) begin
							rp_q <= rp_inc;
						end
					end
					S_INS_B: begin
						wp_q  <= wp_q + 1'b1;
						rp_q  <= t_cnt;
						end_q <= n_q;
					end
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= out_d;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q           <= in_item;
					resp_q.seg_left  <= '0;
					resp_q.seg_right <= '0;
					resp_q.seg_color <= '0;
					resp_q.status    <= ST_BAD;
					resp_q.last      <= 1'b1;
				end
			end
			S_SCAN: begin
				idx_s1 <= rp_q[IDX_W-1:0];
				if (vld_s1) begin
					if (!got_i_q && !cmp.lt_a) begin
						i_q       <= idx_s1;
						eq_q      <= cmp.le_a;
						color_i_q <= rd_data.color;
					end
					if (!got_t_q && !cmp.le_b) begin
						t_q       <= idx_s1;
						color_t_q <= rd_data.color;
					end
					if (!got_c_q && !cmp.le_a) begin
						qcolor_q <= rd_data.color;
					end
				end
			end
			S_DECIDE: begin
				add_q <= add_d;
				if (item_q.cmd == CMD_QUERY) begin
					resp_q.seg_color <= qcolor_q;
					resp_q.status    <= ST_OK;
				end else begin
					resp_q.status    <= ST_FULL;
				end
			end
			S_INS_A: pos_q <= item_q.start_key;
			S_EMIT_WAIT: begin
				if (out_free) begin
					pos_q <= rd_data.key;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

FILE: rtl/interval_paint_map_core.sv
// ---------------------------------------------------------------------------
// interval_paint_map_core
// Breakpoint table of colored key segments with range paint and point query.
// ---------------------------------------------------------------------------
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------------------
//   in        | in_valid / in_stall       | in_item  (cmd, keys, color)
//   out       | out_valid / out_stall     | out_item (segment, status, last)
//   config    | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// A query scans the n breakpoints held in the table. A paint scans the
// table, copies the entries on both sides of the painted range into the
// spare bank at one entry a cycle, and reports each covered segment in
// turn; all of it goes through the single bank read port.
// After reset and after every register write the block rebuilds the single
// initial segment with in_stall high.
// A stalled result holds in the output register; the sequencer waits on it.
//
// Each transaction on the in channel is worked to completion before in_stall
// drops again. A paint reports the old segments it covers, left to right,
// with last set on the final one; a query, a bad range or a table overflow
// reports one result.
// ---------------------------------------------------------------------------
`default_nettype none

module interval_paint_map_core
	import ipm_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_item,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [KEY_W-1:0]   key_limit_q;
	logic [COLOR_W-1:0] init_color_q;
	logic               cfg_write;
	logic               reg_idx;

	mem_ctl_t           mem_ctl;
	logic [IDX_W-1:0]   rd_addr, wr_addr;
	entry_t             wr_data, rd_data, rd_data0, rd_data1;

	// Register index sits at word granularity; low address bits are ignored.
	assign reg_idx   = paddr[2];
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_limit_q  <= '1;
			init_color_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_KEY_LIMIT:  key_limit_q  <= pwdata[KEY_W-1:0];
				REG_INIT_COLOR: init_color_q <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the register selected by the address.
	always_comb begin
		unique case (reg_idx)
			REG_KEY_LIMIT:  prdata = APB_DATA_W'(key_limit_q);
			REG_INIT_COLOR: prdata = APB_DATA_W'(init_color_q);
			default:        prdata = '0;
		endcase
	end

	// Two banks: one holds the live table, the other takes the rebuilt one.
	ipm_mem #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_bank0 (
		.clk     (clk),
		.wr_en   (mem_ctl.wr_en && !mem_ctl.wr_bank),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (mem_ctl.rd_en && !mem_ctl.rd_bank),
		.rd_addr (rd_addr),
		.rd_data (rd_data0)
	);

	ipm_mem #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_bank1 (
		.clk     (clk),
		.wr_en   (mem_ctl.wr_en && mem_ctl.wr_bank),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (mem_ctl.rd_en && mem_ctl.rd_bank),
		.rd_addr (rd_addr),
		.rd_data (rd_data1)
	);

	// The live bank only flips once no read is in flight.
	assign rd_data = mem_ctl.rd_bank ? rd_data1 : rd_data0;

	ipm_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_limit  (key_limit_q),
		.init_color (init_color_q),
		.cfg_write  (cfg_write),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.mem_ctl    (mem_ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_data    (rd_data)
	);

endmodule

`default_nettype wire

FILE: rtl/ipm_chk.sv
// ---------------------------------------------------------------------------
// ipm_chk
// Port-level checks for the interval paint map, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "interval_paint_map_core_assert.svh"

module ipm_chk
	import ipm_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire in_item_t  in_item,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_item_t out_item,
	input wire logic      psel,
	input wire logic      penable,
	input wire logic      pwrite,
	input wire logic      pready
);

	`IPM_ASSERT_IMP(a_err_is_last, out_valid && out_item.status != ST_OK, out_item.last, "error result without last")
	`IPM_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall, "ready right after a transaction")
	`IPM_ASSERT_NXT(a_busy_after_cfg, psel && penable && pwrite && pready, in_stall, "no rebuild after register write")
	`IPM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

endmodule

bind interval_paint_map_core ipm_chk u_chk (.*);

`default_nettype wire
